[hw/rtl/frc_pkg.sv]
package frc_pkg;

  localparam int unsigned MIN_STORED_BYTES = 21;
  localparam int unsigned ROOM_POSITION    = 3;

  localparam logic [8:0] MIN_STORED = 9'(MIN_STORED_BYTES);
  localparam logic [8:0] ROOM_POS   = 9'(ROOM_POSITION);

  localparam logic [7:0] START_BYTE_RST = 8'd0;
  localparam logic [7:0] END_BYTE_RST   = 8'd0;
  localparam logic [8:0] MIN_TOTAL_RST  = 9'd21;
  localparam logic [8:0] MAX_TOTAL_RST  = 9'd258;
  localparam logic [8:0] BUF_LIMIT_RST  = 9'd258;
  localparam logic [7:0] LOCAL_ROOM_RST = 8'd0;
  localparam logic [7:0] BCAST_ROOM_RST = 8'd255;

  // header bytes ahead of the body: start, length high, length low
  localparam logic [8:0] HDR_LEN = 9'd3;

  typedef enum logic [2:0] {
    REG_START_BYTE = 3'd0,
    REG_END_BYTE   = 3'd1,
    REG_MIN_TOTAL  = 3'd2,
    REG_MAX_TOTAL  = 3'd3,
    REG_BUF_LIMIT  = 3'd4,
    REG_LOCAL_ROOM = 3'd5,
    REG_BCAST_ROOM = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_NONE       = 3'd0,
    ST_ACCEPTED   = 3'd1,
    ST_OTHER_ROOM = 3'd2,
    ST_BAD_FRAME  = 3'd3,
    ST_BAD_LENGTH = 3'd4,
    ST_OVERFLOW   = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    PH_WAIT   = 4'b0001,
    PH_LEN_HI = 4'b0010,
    PH_LEN_LO = 4'b0100,
    PH_BODY   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] end_byte;
    logic [8:0] min_total_len;
    logic [8:0] max_total_len;
    logic [8:0] buffer_limit;
    logic [7:0] local_room;
    logic [7:0] broadcast_room;
  } cfg_t;

  // classified byte handed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       is_start;
    logic       is_end;
  } item_t;

  // 8-bit sum with end-around carry
  function automatic logic [7:0] fold_add(input logic [7:0] s, input logic [7:0] b);
    logic [8:0] t;
    t = {1'b0, s} + {1'b0, b};
    return t[7:0] + {7'd0, t[8]};
  endfunction

endpackage

[hw/rtl/frc_front.sv]
module frc_front (
  input  logic          clk,
  input  logic          rst,
  input  frc_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    rx_byte,
  output logic          q_valid,
  output frc_pkg::item_t q_item,
  input  logic          q_pop
);
  import frc_pkg::*;

  item_t      slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  item_t      item_in;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slot[rd_ptr];

  always_comb begin
    item_in.data     = rx_byte;
    item_in.is_start = (rx_byte == cfg.start_byte);
    item_in.is_end   = (rx_byte == cfg.end_byte);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

[hw/rtl/frc_back.sv]
module frc_back (
  input  logic           clk,
  input  logic           rst,
  input  frc_pkg::cfg_t  cfg,
  input  logic           q_valid,
  input  frc_pkg::item_t q_item,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           in_frame,
  output logic [8:0]     byte_index,
  output logic           frame_end,
  output logic [2:0]     frame_status
);
  import frc_pkg::*;

  phase_t     phase, phase_next;
  logic [7:0] len_hi, len_hi_next;
  logic [8:0] total_len, total_len_next;
  logic [8:0] byte_count, byte_count_next;
  logic [7:0] run_sum, run_sum_next;
  logic [7:0] check, check_next;
  logic [7:0] room, room_next;

  logic       take;
  logic       stored_next;
  logic [8:0] index_next;
  logic       end_next;
  status_t    status_next;
  logic [8:0] cnt_inc;
  logic [8:0] tot;
  logic [7:0] sum_fold;
  logic [7:0] b;

  assign take  = q_valid && (!out_valid || out_ready);
  assign q_pop = take;
  assign b     = q_item.data;

  always_comb begin
    cnt_inc  = byte_count + 9'd1;
    tot      = {1'b0, b} + HDR_LEN;
    sum_fold = fold_add(run_sum, b);

    phase_next      = phase;
    len_hi_next     = len_hi;
    total_len_next  = total_len;
    byte_count_next = byte_count;
    run_sum_next    = run_sum;
    check_next      = check;
    room_next       = room;
    stored_next     = 1'b0;
    index_next      = 9'd0;
    end_next        = 1'b0;
    status_next     = ST_NONE;

    unique case (phase)
      PH_WAIT: begin
        if (q_item.is_start) begin
          stored_next     = 1'b1;
          run_sum_next    = b;
          len_hi_next     = 8'd0;
          check_next      = 8'd0;
          room_next       = 8'd0;
          byte_count_next = 9'd1;
          phase_next      = PH_LEN_HI;
        end
      end
      PH_LEN_HI, PH_LEN_LO: begin
        if (byte_count > cfg.buffer_limit) begin
          end_next    = 1'b1;
          status_next = ST_OVERFLOW;
          phase_next  = PH_WAIT;
        end else begin
          stored_next     = 1'b1;
          index_next      = byte_count;
          byte_count_next = cnt_inc;
          run_sum_next    = sum_fold;
          if (phase == PH_LEN_HI) begin
            len_hi_next = b;
            phase_next  = PH_LEN_LO;
          end else begin
            total_len_next = {len_hi[0], b} + HDR_LEN;
            if (len_hi != 8'd0 || tot < cfg.min_total_len || tot > cfg.max_total_len) begin
              end_next    = 1'b1;
              status_next = ST_BAD_LENGTH;
              phase_next  = PH_WAIT;
            end else begin
              byte_count_next = HDR_LEN;
              phase_next      = PH_BODY;
            end
          end
        end
      end
      PH_BODY: begin
        if (byte_count >= cfg.buffer_limit) begin
          end_next    = 1'b1;
          status_next = ST_OVERFLOW;
          phase_next  = PH_WAIT;
        end else begin
          stored_next     = 1'b1;
          index_next      = byte_count;
          byte_count_next = cnt_inc;
          if (byte_count == ROOM_POS) begin
            room_next = b;
          end
          // checksum byte sits one before the end byte and stays out of the sum
          if (cnt_inc != total_len - 9'd1) begin
            run_sum_next = sum_fold;
          end else begin
            check_next = b;
          end
          if (cnt_inc == total_len) begin
            end_next   = 1'b1;
            phase_next = PH_WAIT;
            if (q_item.is_end && run_sum_next == check_next && cnt_inc >= MIN_STORED) begin
              status_next = (room_next == cfg.broadcast_room || room_next == cfg.local_room)
                            ? ST_ACCEPTED : ST_OTHER_ROOM;
            end else begin
              status_next = ST_BAD_FRAME;
            end
          end
        end
      end
      default: begin
        phase_next = PH_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_WAIT;
      len_hi     <= 8'd0;
      total_len  <= 9'd0;
      byte_count <= 9'd0;
      run_sum    <= 8'd0;
      check      <= 8'd0;
      room       <= 8'd0;
      out_valid  <= 1'b0;
    end else if (take) begin
      phase      <= phase_next;
      len_hi     <= len_hi_next;
      total_len  <= total_len_next;
      byte_count <= byte_count_next;
      run_sum    <= run_sum_next;
      check      <= check_next;
      room       <= room_next;
      out_valid  <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte     <= b;
      in_frame     <= stored_next;
      byte_index   <= index_next;
      frame_end    <= end_next;
      frame_status <= status_next;
    end
  end

`ifndef SYNTHESIS
  a_status_only_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_end |-> frame_status == ST_NONE)
    else $error("status without frame end");

  a_index_zero_outside: assert property (@(posedge clk) disable iff (rst)
    out_valid && !in_frame |-> byte_index == 9'd0)
    else $error("index on unstored beat");

  a_overflow_not_stored: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_status == ST_OVERFLOW |-> !in_frame && frame_end)
    else $error("overflow beat marked stored");

  a_end_returns_wait: assert property (@(posedge clk) disable iff (rst)
    take && end_next |=> phase == PH_WAIT)
    else $error("phase not back to wait after frame end");
`endif

endmodule

[hw/rtl/frame_receiver_checksum_top.sv]
// Frame receiver with folded byte checksum.
// A beat accepted at the input is held in the two-entry input queue until the back
// end takes it into the output register.
// Throughput: one byte per cycle while neither side stalls; the two-entry queue and output register let
// input and output stall independently.
// Reset: config registers return to defaults, queue empties, parser waits for start.
module frame_receiver_checksum_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [8:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       in_frame,
  output logic [8:0] byte_index,
  output logic       frame_end,
  output logic [2:0] frame_status
);
  import frc_pkg::*;

  cfg_t  cfg;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte     <= START_BYTE_RST;
      cfg.end_byte       <= END_BYTE_RST;
      cfg.min_total_len  <= MIN_TOTAL_RST;
      cfg.max_total_len  <= MAX_TOTAL_RST;
      cfg.buffer_limit   <= BUF_LIMIT_RST;
      cfg.local_room     <= LOCAL_ROOM_RST;
      cfg.broadcast_room <= BCAST_ROOM_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_START_BYTE: cfg.start_byte     <= cfg_data[7:0];
        REG_END_BYTE:   cfg.end_byte       <= cfg_data[7:0];
        REG_MIN_TOTAL:  cfg.min_total_len  <= cfg_data;
        REG_MAX_TOTAL:  cfg.max_total_len  <= cfg_data;
        REG_BUF_LIMIT:  cfg.buffer_limit   <= cfg_data;
        REG_LOCAL_ROOM: cfg.local_room     <= cfg_data[7:0];
        REG_BCAST_ROOM: cfg.broadcast_room <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  frc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  frc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .in_frame     (in_frame),
    .byte_index   (byte_index),
    .frame_end    (frame_end),
    .frame_status (frame_status)
  );

endmodule

[sim/frame_receiver_checksum_checker.sv]
`timescale 1ns / 100ps

module frame_receiver_checksum_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_byte,
  input  logic        in_frame,
  input  logic [8:0]  byte_index,
  input  logic        frame_end,
  input  logic [2:0]  frame_status,
  output int unsigned errors,
  output int unsigned pending
);
  import frc_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       stored;
    logic [8:0] index;
    logic       last;
    status_t    status;
  } echo_t;

  echo_t       due_echoes[$];
  int unsigned fail_tally = 0;

  // shadow of the register file and the parser
  cfg_t        regs;
  phase_t      phase;
  logic [15:0] len_field;
  logic [8:0]  total_len;
  logic [8:0]  count;
  logic [7:0]  sum;
  logic [7:0]  check;
  logic [7:0]  room;

  function automatic logic [7:0] add_folded(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] wide;
    wide = a + b;
    return wide[7:0] + wide[8];
  endfunction

  task automatic parse_byte(input logic [7:0] b, output echo_t e);
    logic [16:0] tot;
    e = '{data: b, stored: 1'b0, index: '0, last: 1'b0, status: ST_NONE};
    case (phase)
      PH_WAIT: begin
        if (b == regs.start_byte) begin
          e.stored  = 1'b1;
          sum       = b;
          len_field = '0;
          check     = '0;
          room      = '0;
          count     = 9'd1;
          phase     = PH_LEN_HI;
        end
      end
      PH_LEN_HI, PH_LEN_LO: begin
        if (count > regs.buffer_limit) begin
          e.last   = 1'b1;
          e.status = ST_OVERFLOW;
          phase    = PH_WAIT;
        end else begin
          e.stored = 1'b1;
          e.index  = count;
          count    = count + 9'd1;
          sum      = add_folded(sum, b);
          if (phase == PH_LEN_HI) begin
            len_field = {b, 8'h00};
            phase     = PH_LEN_LO;
          end else begin
            len_field[7:0] = b;
            tot            = {1'b0, len_field} + 17'd3;
            total_len      = tot[8:0];
            if (len_field[15:8] != 8'h00 || tot < regs.min_total_len ||
                tot > regs.max_total_len) begin
              e.last   = 1'b1;
              e.status = ST_BAD_LENGTH;
              phase    = PH_WAIT;
            end else begin
              count = 9'd3;
              phase = PH_BODY;
            end
          end
        end
      end
      default: begin
        if (count >= regs.buffer_limit) begin
          e.last   = 1'b1;
          e.status = ST_OVERFLOW;
          phase    = PH_WAIT;
        end else begin
          e.stored = 1'b1;
          e.index  = count;
          if (count == ROOM_POS)
            room = b;
          count = count + 9'd1;
          // checksum byte sits one ahead of the last byte and stays out of the sum
          if (count != total_len - 9'd1)
            sum = add_folded(sum, b);
          else
            check = b;
          if (count == total_len) begin
            e.last = 1'b1;
            if (b == regs.end_byte && sum == check && count >= MIN_STORED)
              e.status = (room == regs.broadcast_room || room == regs.local_room) ?
                         ST_ACCEPTED : ST_OTHER_ROOM;
            else
              e.status = ST_BAD_FRAME;
            phase = PH_WAIT;
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    echo_t want;
    echo_t got;
    if (rst) begin
      due_echoes.delete();
      regs.start_byte     = START_BYTE_RST;
      regs.end_byte       = END_BYTE_RST;
      regs.min_total_len  = MIN_TOTAL_RST;
      regs.max_total_len  = MAX_TOTAL_RST;
      regs.buffer_limit   = BUF_LIMIT_RST;
      regs.local_room     = LOCAL_ROOM_RST;
      regs.broadcast_room = BCAST_ROOM_RST;
      phase     = PH_WAIT;
      len_field = '0;
      total_len = '0;
      count     = '0;
      sum       = '0;
      check     = '0;
      room      = '0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{data: out_byte, stored: in_frame, index: byte_index, last: frame_end,
                status: status_t'(frame_status)};
        if (due_echoes.size() == 0) begin
          fail_tally++;
          if (fail_tally <= 10)
            $display("unexpected result beat: byte %h frame %b idx %0d end %b status %0d",
                     got.data, got.stored, got.index, got.last, got.status);
        end else begin
          want = due_echoes.pop_front();
          if (got.data !== want.data || got.stored !== want.stored ||
              got.index !== want.index || got.last !== want.last ||
              got.status !== want.status) begin
            fail_tally++;
            // fields: byte/frame/idx/end/status
            if (fail_tally <= 10)
              $display("result mismatch: want %h/%b/%0d/%b/%0d got %h/%b/%0d/%b/%0d",
                       want.data, want.stored, want.index, want.last, want.status,
                       got.data, got.stored, got.index, got.last, got.status);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_START_BYTE: regs.start_byte     = cfg_data[7:0];
          REG_END_BYTE:   regs.end_byte       = cfg_data[7:0];
          REG_MIN_TOTAL:  regs.min_total_len  = cfg_data;
          REG_MAX_TOTAL:  regs.max_total_len  = cfg_data;
          REG_BUF_LIMIT:  regs.buffer_limit   = cfg_data;
          REG_LOCAL_ROOM: regs.local_room     = cfg_data[7:0];
          REG_BCAST_ROOM: regs.broadcast_room = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        parse_byte(rx_byte, want);
        due_echoes = {due_echoes, want};
      end
    end
    pending <= due_echoes.size();
    errors  <= fail_tally;
  end

endmodule

[sim/frame_receiver_checksum_top_tb.sv]
`timescale 1ns / 100ps

module frame_receiver_checksum_top_tb;
  import frc_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam logic [2:0]  REG_UNUSED  = 3'd7;

  typedef enum int unsigned {
    FLAW_NONE,
    FLAW_CHECKSUM,
    FLAW_END,
    FLAW_LEN_HIGH,
    FLAW_LEN_RANGE,
    FLAW_CUT
  } flaw_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [8:0]  cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        in_frame;
  logic [8:0]  byte_index;
  logic        frame_end;
  logic [2:0]  frame_status;
  int unsigned errors;
  int unsigned pending;

  logic        calm      = 1'b0;
  logic        hold_req  = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_left = 0;
  int unsigned idle_run  = 0;
  int unsigned phase_bytes;
  cfg_t        plan;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  frame_receiver_checksum_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .in_frame     (in_frame),
    .byte_index   (byte_index),
    .frame_end    (frame_end),
    .frame_status (frame_status)
  );

  frame_receiver_checksum_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .in_frame     (in_frame),
    .byte_index   (byte_index),
    .frame_end    (frame_end),
    .frame_status (frame_status),
    .errors       (errors),
    .pending      (pending)
  );

  // result sink; a new hold request parks it long enough for the block to back up
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_seen <= 1'b0;
    end else begin
      hold_seen <= hold_req;
      if (hold_req && !hold_seen) begin
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 31);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_run <= 0;
    end else if (idle_run == STALL_LIMIT) begin
      $display("frame_receiver_checksum_top verification failed");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  function automatic bit roll_idle();
    return !calm && $urandom_range(99) < 31;
  endfunction

  function automatic logic [7:0] fold_in(input logic [7:0] acc, input logic [7:0] b);
    logic [8:0] wide;
    wide = acc + b;
    return wide[7:0] + wide[8];
  endfunction

  // mostly sizes just above the minimum, now and then anything
  function automatic int unsigned pick_total();
    int unsigned lo;
    int unsigned hi;
    lo = plan.min_total_len;
    hi = plan.max_total_len;
    if (lo > hi || $urandom_range(9) == 0)
      return $urandom_range(258, 5);
    if ($urandom_range(19) == 0)
      return $urandom_range(hi, lo);
    return $urandom_range((hi < lo + 20) ? hi : lo + 20, lo);
  endfunction

  function automatic logic [7:0] pick_room();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 4)
      return plan.local_room;
    if (pick < 7)
      return plan.broadcast_room;
    return 8'($urandom);
  endfunction

  // in_valid stays up across back-to-back beats; it only drops for an idle gap
  task automatic send_byte(input logic [7:0] b);
    if (roll_idle()) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (roll_idle());
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    phase_bytes++;
  endtask

  task automatic send_packet(input int unsigned tot, input flaw_t flaw, input logic [7:0] room);
    logic [7:0]  fb [0:257];
    logic [7:0]  csum;
    int unsigned n;
    fb[0] = plan.start_byte;
    fb[1] = 8'((tot - 3) >> 8);
    fb[2] = 8'(tot - 3);
    fb[3] = room;
    for (int i = 4; i < tot; i++)
      fb[i] = 8'($urandom);
    fb[tot-1] = plan.end_byte;
    if (flaw == FLAW_END)
      fb[tot-1] ^= 8'($urandom_range(255, 1));
    csum = 8'h00;
    for (int i = 0; i < tot; i++)
      if (i != tot - 2)
        csum = fold_in(csum, fb[i]);
    fb[tot-2] = csum;
    n = tot;
    case (flaw)
      FLAW_CHECKSUM:  fb[tot-2] ^= 8'($urandom_range(255, 1));
      FLAW_LEN_HIGH:  fb[1] = 8'($urandom_range(255, 1));
      FLAW_LEN_RANGE: fb[2] = 8'($urandom);
      FLAW_CUT:       n = $urandom_range(tot - 1, 1);
      default: ;
    endcase
    for (int i = 0; i < n; i++)
      send_byte(fb[i]);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [8:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic apply_plan();
    write_reg(REG_UNUSED, 9'($urandom));
    write_reg(REG_START_BYTE, {1'b0, plan.start_byte});
    write_reg(REG_END_BYTE, {1'b0, plan.end_byte});
    write_reg(REG_MIN_TOTAL, plan.min_total_len);
    write_reg(REG_MAX_TOTAL, plan.max_total_len);
    write_reg(REG_BUF_LIMIT, plan.buffer_limit);
    write_reg(REG_LOCAL_ROOM, {1'b0, plan.local_room});
    write_reg(REG_BCAST_ROOM, {1'b0, plan.broadcast_room});
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    calm     <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int unsigned budget [0:5];
    int unsigned roll;
    bit          first;
    budget = '{250, 300, 400, 200, 200, 200};
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < 6; p++) begin
      phase_bytes = 0;
      case (p)
        0: plan = '{start_byte: START_BYTE_RST, end_byte: END_BYTE_RST,
                    min_total_len: MIN_TOTAL_RST, max_total_len: MAX_TOTAL_RST,
                    buffer_limit: BUF_LIMIT_RST, local_room: LOCAL_ROOM_RST,
                    broadcast_room: BCAST_ROOM_RST};
        1: plan = '{start_byte: 8'h7E, end_byte: 8'h7F, min_total_len: 9'd5,
                    max_total_len: 9'd258, buffer_limit: 9'd258,
                    local_room: 8'($urandom), broadcast_room: 8'hFF};
        // only the longest frame passes
        2: plan = '{start_byte: 8'hFF, end_byte: 8'h00, min_total_len: 9'd258,
                    max_total_len: 9'd258, buffer_limit: 9'd258,
                    local_room: 8'hFF, broadcast_room: 8'h00};
        // shortest everything: frames of five bytes fit exactly
        3: plan = '{start_byte: 8'h00, end_byte: 8'hFF, min_total_len: 9'd5,
                    max_total_len: 9'd5, buffer_limit: 9'd5,
                    local_room: 8'h55, broadcast_room: 8'hAA};
        // length passes but the buffer fills first for frames over 30 bytes
        4: plan = '{start_byte: 8'hA5, end_byte: 8'h5A, min_total_len: 9'd21,
                    max_total_len: 9'd100, buffer_limit: 9'd30,
                    local_room: 8'($urandom), broadcast_room: 8'($urandom)};
        default: plan = '{start_byte: 8'($urandom), end_byte: 8'($urandom),
                          min_total_len: 9'($urandom_range(40, 5)),
                          max_total_len: 9'($urandom_range(258, 5)),
                          buffer_limit: 9'($urandom_range(258, 5)),
                          local_room: 8'($urandom), broadcast_room: 8'($urandom)};
      endcase
      if (p > 0)
        apply_plan();

      if (p == 0) begin
        send_byte(8'hFF);                     // not a start byte, ignored
        send_byte(8'h00);                     // start byte of a frame whose length high byte is nonzero
        send_byte(8'h01);
        send_byte(8'h00);
        send_byte(8'h00);                     // total of 3, below the minimum
        send_byte(8'h00);
        send_byte(8'h00);
        send_packet(21, FLAW_NONE, plan.local_room);
      end

      first = 1'b1;
      while (phase_bytes < budget[p]) begin
        hold_req <= first && (p == 1 || p == 4);
        calm     <= (p == 1 && phase_bytes >= 150 && phase_bytes < 300);
        first = 1'b0;
        roll  = $urandom_range(99);
        if (roll < 55)
          send_packet(pick_total(), FLAW_NONE, pick_room());
        else if (roll < 80)
          send_packet(pick_total(), flaw_t'($urandom_range(5, 1)), pick_room());
        else
          repeat ($urandom_range(4, 1))
            send_byte(($urandom_range(3) == 0) ? plan.start_byte : 8'($urandom));
      end
      hold_req <= 1'b0;
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("frame_receiver_checksum_top verification clean");
    else
      $display("frame_receiver_checksum_top verification failed");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/frc_pkg.sv
hw/rtl/frc_front.sv
hw/rtl/frc_back.sv
hw/rtl/frame_receiver_checksum_top.sv
sim/frame_receiver_checksum_checker.sv
sim/frame_receiver_checksum_top_tb.sv
